// ===== sv/sfcs_pkg.sv =====
// Shared types, codes and helper functions of the SPI flash command sequencer.
// Used by the front, queue, back and top level modules; depends on nothing.
package sfcs_pkg;

  // Default sizes of the flash geometry and of the job queue.
  localparam int unsigned PAGE_BYTES_DEF   = 256;
  localparam int unsigned SECTOR_BYTES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  // Reset values of the configuration registers.
  localparam logic [15:0] POLL_LIMIT_RST = 16'd10000;
  localparam logic [15:0] WAIT_TIME_RST  = 16'd1000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_READY = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_WAIT_TIME    = 2'd2;

  // Input actions.
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_PROG   = 2'd1;
  localparam logic [1:0] ACT_ERASE  = 2'd2;
  localparam logic [1:0] ACT_STATUS = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_WAIT  = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // Flash opcodes.
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_PROG  = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'h20;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;

  // Status register bits.
  localparam int unsigned ST_WEL_BIT = 1;
  localparam int unsigned ST_WIP_BIT = 0;

  localparam logic [1:0] ADDR_BYTES = 2'd3;

  // One input word.
  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] address;
    logic [24:0] length;
    logic [7:0]  status_byte;
  } in_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic [23:0] frame_address;
    logic [1:0]  address_bytes;
    logic [24:0] byte_count;
    logic        reads_back;
    logic [15:0] wait_us;
    logic        last;
  } out_t;

  // Configuration register set.
  typedef struct packed {
    logic        device_ready;
    logic [15:0] poll_limit;
    logic [15:0] wait_time_us;
  } cfg_t;

  // Job codes: each names a fixed sequence of one to three result words.
  typedef enum logic [2:0] {
    JOB_ERR,
    JOB_OK,
    JOB_READ,
    JOB_START,
    JOB_RETRY,
    JOB_TIMEOUT,
    JOB_PROG,
    JOB_ERASE
  } job_code_e;

  // A classified job handed from the front to the back.
  typedef struct packed {
    job_code_e   code;
    logic [23:0] address;
    logic [24:0] count;
    logic [15:0] wait_us;
  } job_t;

  // Number of result words that a job produces.
  function automatic logic [1:0] job_len(job_code_e code);
    logic [1:0] len;
    case (code)
      JOB_ERR, JOB_OK: len = 2'd1;
      JOB_PROG:        len = 2'd3;
      default:         len = 2'd2;
    endcase
    return len;
  endfunction

  // Result word number step of a job.
  function automatic out_t expand(job_t job, logic [1:0] step);
    out_t r;
    r = '0;
    case (job.code)
      JOB_ERR: begin
        r.kind = KIND_ERR;
      end
      JOB_OK: begin
        r.kind = KIND_OK;
      end
      JOB_READ: begin
        if (step == 2'd0) begin
          r.kind          = KIND_FRAME;
          r.opcode        = OP_READ;
          r.frame_address = job.address;
          r.address_bytes = ADDR_BYTES;
          r.byte_count    = job.count;
          r.reads_back    = 1'b1;
        end else begin
          r.kind = KIND_OK;
        end
      end
      JOB_START: begin
        r.kind = KIND_FRAME;
        if (step == 2'd0) begin
          r.opcode = OP_WREN;
        end else begin
          r.opcode     = OP_RDSR;
          r.byte_count = 25'd1;
          r.reads_back = 1'b1;
        end
      end
      JOB_RETRY: begin
        if (step == 2'd0) begin
          r.kind    = KIND_WAIT;
          r.wait_us = job.wait_us;
        end else begin
          r.kind       = KIND_FRAME;
          r.opcode     = OP_RDSR;
          r.byte_count = 25'd1;
          r.reads_back = 1'b1;
        end
      end
      JOB_TIMEOUT: begin
        if (step == 2'd0) begin
          r.kind    = KIND_WAIT;
          r.wait_us = job.wait_us;
        end else begin
          r.kind = KIND_ERR;
        end
      end
      JOB_PROG: begin
        if (step == 2'd0) begin
          r.kind          = KIND_FRAME;
          r.opcode        = OP_PROG;
          r.frame_address = job.address;
          r.address_bytes = ADDR_BYTES;
          r.byte_count    = job.count;
        end else if (step == 2'd1) begin
          r.kind    = KIND_WAIT;
          r.wait_us = job.wait_us;
        end else begin
          r.kind       = KIND_FRAME;
          r.opcode     = OP_RDSR;
          r.byte_count = 25'd1;
          r.reads_back = 1'b1;
        end
      end
      JOB_ERASE: begin
        r.kind = KIND_FRAME;
        if (step == 2'd0) begin
          r.opcode        = OP_ERASE;
          r.frame_address = job.address;
          r.address_bytes = ADDR_BYTES;
        end else begin
          r.opcode     = OP_RDSR;
          r.byte_count = 25'd1;
          r.reads_back = 1'b1;
        end
      end
      default: begin
        r.kind = KIND_ERR;
      end
    endcase
    r.last = (step == job_len(job.code) - 2'd1);
    return r;
  endfunction

endpackage

// ===== sv/sfcs_front.sv =====
// Front part of the sequencer: accepts input words, keeps the operation state
// and classifies each word into at most one job. Depends on sfcs_pkg.
module sfcs_front #(
  parameter int unsigned PageBytes   = sfcs_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SectorBytes = sfcs_pkg::SECTOR_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sfcs_pkg::in_t  in_data_i,
  input  sfcs_pkg::cfg_t cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output sfcs_pkg::job_t job_o
);

  // Offsets use a mask; PageBytes must be a power of two (not checked here).
  localparam logic [23:0] PageMask   = 24'(PageBytes - 1);
  localparam logic [25:0] PageLen    = 26'(PageBytes);
  localparam logic [24:0] PageCount  = 25'(PageBytes);
  localparam logic [23:0] SectorStep = 24'(SectorBytes);
  localparam logic [24:0] SectorLen  = 25'(SectorBytes);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WEL  = 2'd1;
  localparam logic [1:0] PH_WIP  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic        op_erase_q, op_erase_d;
  logic [23:0] cur_q, cur_d;
  logic [24:0] rem_q, rem_d;
  logic [15:0] poll_q, poll_d;

  logic        accept;
  logic        idle;
  logic [23:0] offset;
  logic [24:0] chunk;
  logic [15:0] poll_next;
  logic [15:0] limit;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign idle       = (phase_q != PH_WEL) && (phase_q != PH_WIP);

  // Program chunk: the rest of the current page or the remaining length.
  assign offset = cur_q & PageMask;
  assign chunk  = (({2'b00, offset} + {1'b0, rem_q}) < PageLen) ?
                  rem_q : (PageCount - offset[24-1:0] );

  // Poll counting; a zero limit acts like one.
  assign poll_next = poll_q + 16'd1;
  assign limit     = (cfg_i.poll_limit == 16'd0) ? 16'd1 : cfg_i.poll_limit;

  // Classification and state update for an accepted word.
  always_comb begin
    phase_d       = phase_q;
    op_erase_d    = op_erase_q;
    cur_d         = cur_q;
    rem_d         = rem_q;
    poll_d        = poll_q;
    push_o        = 1'b0;
    job_o.code    = sfcs_pkg::JOB_OK;
    job_o.address = in_data_i.address;
    job_o.count   = in_data_i.length;
    job_o.wait_us = cfg_i.wait_time_us;
    if (accept) begin
      if (in_data_i.action != sfcs_pkg::ACT_STATUS) begin
        if (idle) begin
          phase_d = PH_IDLE;
          push_o  = 1'b1;
          if (!cfg_i.device_ready) begin
            job_o.code = sfcs_pkg::JOB_ERR;
          end else if (in_data_i.action == sfcs_pkg::ACT_READ) begin
            job_o.code = sfcs_pkg::JOB_READ;
          end else begin
            op_erase_d = (in_data_i.action == sfcs_pkg::ACT_ERASE);
            cur_d      = in_data_i.address;
            rem_d      = in_data_i.length;
            if (in_data_i.length == 25'd0) begin
              job_o.code = sfcs_pkg::JOB_OK;
            end else begin
              job_o.code = sfcs_pkg::JOB_START;
              phase_d    = PH_WEL;
              poll_d     = 16'd0;
            end
          end
        end
      end else if (!idle) begin
        push_o = 1'b1;
        if ((phase_q == PH_WEL && in_data_i.status_byte[sfcs_pkg::ST_WEL_BIT]) ||
            (phase_q == PH_WIP && in_data_i.status_byte[sfcs_pkg::ST_WIP_BIT])) begin
          if (phase_q == PH_WEL) begin
            // Latch set: issue the page program or sector erase.
            job_o.address = cur_q;
            phase_d       = PH_WIP;
            poll_d        = 16'd0;
            if (!op_erase_q) begin
              job_o.code  = sfcs_pkg::JOB_PROG;
              job_o.count = chunk;
              cur_d       = cur_q + chunk[23:0];
              rem_d       = rem_q - chunk;
            end else begin
              job_o.code = sfcs_pkg::JOB_ERASE;
              cur_d      = cur_q + SectorStep;
              rem_d      = (rem_q <= SectorLen) ? 25'd0 : (rem_q - SectorLen);
            end
          end else begin
            // Still busy: a failed poll.
            if (poll_next >= limit) begin
              job_o.code = sfcs_pkg::JOB_TIMEOUT;
              phase_d    = PH_IDLE;
              poll_d     = 16'd0;
            end else begin
              job_o.code = sfcs_pkg::JOB_RETRY;
              poll_d     = poll_next;
            end
          end
        end else if (phase_q == PH_WEL) begin
          // Latch not yet set: a failed poll.
          if (poll_next >= limit) begin
            job_o.code = sfcs_pkg::JOB_TIMEOUT;
            phase_d    = PH_IDLE;
            poll_d     = 16'd0;
          end else begin
            job_o.code = sfcs_pkg::JOB_RETRY;
            poll_d     = poll_next;
          end
        end else if (rem_q == 25'd0) begin
          job_o.code = sfcs_pkg::JOB_OK;
          phase_d    = PH_IDLE;
          poll_d     = 16'd0;
        end else begin
          job_o.code = sfcs_pkg::JOB_START;
          phase_d    = PH_WEL;
          poll_d     = 16'd0;
        end
      end
    end
  end

  // Operation state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      op_erase_q <= 1'b0;
      cur_q      <= '0;
      rem_q      <= '0;
      poll_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      op_erase_q <= op_erase_d;
      cur_q      <= cur_d;
      rem_q      <= rem_d;
      poll_q     <= poll_d;
    end
  end

endmodule

// ===== sv/sfcs_queue.sv =====
// Short job queue between the front and back parts of the sequencer.
// Depends on sfcs_pkg for the job type.
module sfcs_queue #(
  parameter int unsigned Depth = sfcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfcs_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output sfcs_pkg::job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sfcs_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Job storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== sv/sfcs_back.sv =====
// Back part of the sequencer: expands queued jobs into result words into an
// output register, one per cycle unless it stalls. Depends on sfcs_pkg.
module sfcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  sfcs_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sfcs_pkg::out_t out_data_o
);

  logic [1:0]     step_q, step_d;
  logic           valid_q, valid_d;
  sfcs_pkg::out_t data_q, data_d;
  logic           load;

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Load the next result word whenever the output register is free.
  assign load   = head_valid_i && (!valid_q || !out_stall_i);
  assign data_d = sfcs_pkg::expand(head_i, step_q);
  assign pop_o  = load && data_d.last;

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      step_d  = data_d.last ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== sv/spi_flash_command_sequencer_unit.sv =====
// Top level of the SPI flash command sequencer: configuration registers and
// the front, queue and back parts. Depends on sfcs_pkg and the sfcs modules.
//
// An input word (request or status byte) is taken whenever the job queue
// has room, and causes zero to three result words. The back part puts out
// one result word per cycle through its output register while the output
// is not stalled; that output register sets the sustained rate. The queue
// holds QueueDepth jobs, so the front keeps taking words while results wait
// on a stalled output. Configuration writes are accepted in every cycle and
// take effect as soon as they are registered.
// PageBytes must be a power of two.
module spi_flash_command_sequencer_unit #(
  parameter int unsigned PageBytes   = sfcs_pkg::PAGE_BYTES_DEF,
  parameter int unsigned SectorBytes = sfcs_pkg::SECTOR_BYTES_DEF,
  parameter int unsigned QueueDepth  = sfcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sfcs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sfcs_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);

  sfcs_pkg::cfg_t cfg_q;
  sfcs_pkg::job_t push_job;
  sfcs_pkg::job_t head_job;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_head_valid;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_ready <= 1'b0;
      cfg_q.poll_limit   <= sfcs_pkg::POLL_LIMIT_RST;
      cfg_q.wait_time_us <= sfcs_pkg::WAIT_TIME_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sfcs_pkg::CFG_DEVICE_READY: cfg_q.device_ready <= cfg_data_i[0];
        sfcs_pkg::CFG_POLL_LIMIT:   cfg_q.poll_limit   <= cfg_data_i;
        sfcs_pkg::CFG_WAIT_TIME:    cfg_q.wait_time_us <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfcs_front #(
    .PageBytes  (PageBytes),
    .SectorBytes(SectorBytes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .job_o     (push_job)
  );

  sfcs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .job_i       (push_job),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .head_valid_o(q_head_valid),
    .head_o      (head_job)
  );

  sfcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_head_valid),
    .head_i      (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // The front never writes a job into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // The back only retires a job that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_head_valid)
    else $error("job popped from an empty queue");

  // Retiring a job always leaves its last result word in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_pop |=> (out_valid_o && out_data_o.last))
    else $error("job retired without its last result word");
`endif

endmodule
